/* sv/aesctr_pkg.sv */
`default_nettype none
package aesctr_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] byte_role;
    logic       packet_end;
  } out_item_t;

  typedef struct packed {
    logic         start;
    logic         abort;
    logic [127:0] ctr;
    logic [255:0] key;
  } core_req_t;

  typedef struct packed {
    logic         busy;
    logic         done;
    logic [127:0] ks;
  } core_sts_t;

  localparam logic [1:0] ROLE_CT     = 2'd0;
  localparam logic [1:0] ROLE_CRC_HI = 2'd1;
  localparam logic [1:0] ROLE_CRC_LO = 2'd2;
  localparam logic [1:0] ROLE_META   = 2'd3;

  localparam logic [2:0] CFG_KEY0 = 3'd0;
  localparam logic [2:0] CFG_KEY1 = 3'd1;
  localparam logic [2:0] CFG_KEY2 = 3'd2;
  localparam logic [2:0] CFG_KEY3 = 3'd3;
  localparam logic [2:0] CFG_TS   = 3'd4;

  localparam logic [31:0] IV_HIGH_FIXED = 32'h0000_0102;
  localparam logic [63:0] IV_LOW_FIXED  = 64'h03AA_BBCC_DDEE_FF42;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [3:0]  LAST_ROUND    = 4'd14;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage
`default_nettype wire

/* sv/aesctr_fifo.sv */
`default_nettype none
module aesctr_fifo import aesctr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire in_item_t push_data_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output in_item_t      pop_data_o
);

  in_item_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = cnt_q[1];
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

/* sv/aesctr_core.sv */
`default_nettype none
module aesctr_core import aesctr_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire core_req_t req_i,
  output core_sts_t      sts_o
);

  logic [127:0] st_q;
  logic [255:0] win_q;
  logic [3:0]   rnd_q;
  logic         busy_q;

  function automatic logic [7:0] xt(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rcon(logic [2:0] j);
    logic [7:0] r;
    unique case (j)
      3'd1:    r = 8'h01;
      3'd2:    r = 8'h02;
      3'd3:    r = 8'h04;
      3'd4:    r = 8'h08;
      3'd5:    r = 8'h10;
      3'd6:    r = 8'h20;
      3'd7:    r = 8'h40;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [127:0] aes_round(logic [127:0] st, logic last);
    logic [7:0] t [16];
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) t[i] = SBOX[st[127-8*i -: 8]];
    for (int j = 0; j < 16; j++) s[j] = t[(j % 4) + 4 * (((j / 4) + (j % 4)) % 4)];
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      x  = a0 ^ a1 ^ a2 ^ a3;
      o[4*c]   = last ? a0 : (a0 ^ x ^ xt(a0 ^ a1));
      o[4*c+1] = last ? a1 : (a1 ^ x ^ xt(a1 ^ a2));
      o[4*c+2] = last ? a2 : (a2 ^ x ^ xt(a2 ^ a3));
      o[4*c+3] = last ? a3 : (a3 ^ x ^ xt(a3 ^ a0));
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
    return r;
  endfunction

  // The window holds eight key-schedule words; each round appends the next four.
  function automatic logic [127:0] key_step(logic [255:0] win, logic [3:0] rnd);
    logic [31:0] p, t, n0, n1, n2, n3;
    logic [4:0]  ri;
    p  = win[31:0];
    ri = ({1'b0, rnd} + 5'd1) >> 1;
    if (rnd[0]) begin
      t = {SBOX[p[23:16]] ^ rcon(ri[2:0]), SBOX[p[15:8]], SBOX[p[7:0]], SBOX[p[31:24]]};
    end else begin
      t = {SBOX[p[31:24]], SBOX[p[23:16]], SBOX[p[15:8]], SBOX[p[7:0]]};
    end
    n0 = win[255:224] ^ t;
    n1 = win[223:192] ^ n0;
    n2 = win[191:160] ^ n1;
    n3 = win[159:128] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  assign sts_o.busy = busy_q;
  assign sts_o.done = busy_q && (rnd_q == LAST_ROUND);
  assign sts_o.ks   = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 4'd0;
    end else if (req_i.abort) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      rnd_q  <= 4'd1;
    end else if (busy_q) begin
      rnd_q <= rnd_q + 4'd1;
      if (rnd_q == LAST_ROUND) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !req_i.abort) begin
      st_q  <= req_i.ctr ^ req_i.key[255:128];
      win_q <= req_i.key;
    end else if (busy_q) begin
      st_q  <= aes_round(st_q, rnd_q == LAST_ROUND) ^ win_q[127:0];
      win_q <= {win_q[127:0], key_step(win_q, rnd_q)};
    end
  end

endmodule
`default_nettype wire

/* sv/aesctr_back.sv */
`default_nettype none
module aesctr_back import aesctr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_valid_i,
  input  wire in_item_t     q_data_i,
  output logic              q_pop_o,
  input  wire logic         cfg_we_i,
  input  wire logic [255:0] key_i,
  input  wire logic [31:0]  ts_i,
  output core_req_t         core_req_o,
  input  wire core_sts_t    core_sts_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output out_item_t         out_data_o
);

  logic         out_valid_q, in_pkt_q, pre_valid_q;
  logic [1:0]   trl_q;
  logic [3:0]   pos_q;
  logic [15:0]  crc_q, trl_crc_q, crc_d;
  logic [127:0] ctr_q, cur_ks_q, ctr_eff, ks_sel;
  out_item_t    out_q;
  logic         ov_free, take, abort;
  logic [7:0]   ksb, cbyte;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    return c;
  endfunction

  // Outside a packet the next block needed is the one for the IV.
  assign ctr_eff = in_pkt_q ? ctr_q : {ts_i, IV_HIGH_FIXED, IV_LOW_FIXED};
  assign ov_free = !out_valid_q || out_ready_i;
  assign take    = q_valid_i && (trl_q == 2'd0) && ov_free && ((pos_q != 4'd0) || pre_valid_q);
  assign abort   = (take && q_data_i.last_byte) || cfg_we_i;
  assign ks_sel  = (pos_q == 4'd0) ? core_sts_i.ks : cur_ks_q;
  assign ksb     = ks_sel[7'd127 - {pos_q, 3'b000} -: 8];
  assign cbyte   = q_data_i.data_byte ^ ksb;
  assign crc_d   = crc_byte(crc_q, cbyte);

  assign q_pop_o          = take;
  assign core_req_o.start = !core_sts_i.busy && !pre_valid_q && !abort;
  assign core_req_o.abort = abort;
  assign core_req_o.ctr   = ctr_eff;
  assign core_req_o.key   = key_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      in_pkt_q    <= 1'b0;
      pre_valid_q <= 1'b0;
      trl_q       <= 2'd0;
      pos_q       <= 4'd0;
      crc_q       <= CRC_INIT;
    end else begin
      if (take) begin
        out_valid_q <= 1'b1;
        if (q_data_i.last_byte) begin
          trl_q    <= 2'd3;
          in_pkt_q <= 1'b0;
          pos_q    <= 4'd0;
          crc_q    <= CRC_INIT;
        end else begin
          in_pkt_q <= 1'b1;
          pos_q    <= pos_q + 4'd1;
          crc_q    <= crc_d;
        end
      end else if ((trl_q != 2'd0) && ov_free) begin
        out_valid_q <= 1'b1;
        trl_q       <= trl_q - 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (core_sts_i.done)              pre_valid_q <= 1'b1;
      if (take && (pos_q == 4'd0))      pre_valid_q <= 1'b0;
      if (abort)                        pre_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= '{out_byte: cbyte, byte_role: ROLE_CT, packet_end: 1'b0};
      if (q_data_i.last_byte) trl_crc_q <= crc_d;
      if (pos_q == 4'd0) begin
        cur_ks_q <= core_sts_i.ks;
        ctr_q    <= ctr_eff + 128'd1;
      end
    end else if ((trl_q != 2'd0) && ov_free) begin
      unique case (trl_q)
        2'd3:    out_q <= '{out_byte: trl_crc_q[15:8], byte_role: ROLE_CRC_HI, packet_end: 1'b0};
        2'd2:    out_q <= '{out_byte: trl_crc_q[7:0], byte_role: ROLE_CRC_LO, packet_end: 1'b0};
        default: out_q <= '{out_byte: ts_i[7:0], byte_role: ROLE_META, packet_end: 1'b1};
      endcase
    end
  end

endmodule
`default_nettype wire

/* sv/aes256_ctr_packet_encrypt_crc16.sv */
// A result byte passes through the input FIFO and then the output register before it
// is presented. Throughput: one payload byte per cycle while the output is ready and
// the next keystream block is ready; each packet adds three trailer bytes.
// The first byte of a packet waits for the IV keystream block, which the round unit
// (one AES round per cycle) starts anew after the previous packet's last byte
// or after any register write. Later blocks are made ahead within 16 byte slots.
// Reset clears all control state and the registers; the IV block starts at once.
`default_nettype none
module aes256_ctr_packet_encrypt_crc16 import aesctr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i
);

  logic [63:0] key_q [4];
  logic [31:0] ts_q;
  logic        full, q_valid, q_pop;
  in_item_t    q_data;
  core_req_t   core_req;
  core_sts_t   core_sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '{default: 64'd0};
      ts_q  <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY0: key_q[0] <= cfg_wdata_i;
        CFG_KEY1: key_q[1] <= cfg_wdata_i;
        CFG_KEY2: key_q[2] <= cfg_wdata_i;
        CFG_KEY3: key_q[3] <= cfg_wdata_i;
        CFG_TS:   ts_q     <= cfg_wdata_i[31:0];
        default:  ;
      endcase
    end
  end

  assign in_ready_o = !full;

  aesctr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !full),
    .push_data_i (in_data_i),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  aesctr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (core_req),
    .sts_o  (core_sts)
  );

  aesctr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .cfg_we_i    (cfg_we_i),
    .key_i       ({key_q[0], key_q[1], key_q[2], key_q[3]}),
    .ts_i        (ts_q),
    .core_req_o  (core_req),
    .core_sts_i  (core_sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* sv/aesctr_chk.sv */
`default_nettype none
module aesctr_chk import aesctr_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire out_item_t   out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  a_end_meta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.packet_end |-> out_data_o.byte_role == ROLE_META)
    else $error("packet end on a byte other than the timestamp byte");

  a_hi_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.byte_role == ROLE_CRC_HI
    |=> out_valid_o && out_data_o.byte_role == ROLE_CRC_LO)
    else $error("CRC low byte does not follow CRC high byte");

  a_lo_meta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.byte_role == ROLE_CRC_LO
    |=> out_valid_o && out_data_o.byte_role == ROLE_META && out_data_o.packet_end)
    else $error("timestamp byte does not follow CRC low byte");

endmodule

bind aes256_ctr_packet_encrypt_crc16 aesctr_chk u_chk (.*);
`default_nettype wire
